### rtl/pstf_pkg.sv
package pstf_pkg;

	typedef enum logic [2:0] {
		FMT_INT8    = 3'd0,
		FMT_INT16   = 3'd1,
		FMT_INT24   = 3'd2,
		FMT_INT32   = 3'd3,
		FMT_FLOAT32 = 3'd4,
		FMT_FLOAT64 = 3'd5
	} sample_format_t;

	localparam logic [2:0]  FORMAT_RESET = 3'd1;
	localparam logic [31:0] INF_BITS     = 32'h7f80_0000;
	localparam logic [31:0] QNAN_BIT     = 32'h0040_0000;

	// Stage 1 to stage 2: what the front end decided about one sample.
	typedef enum logic [1:0] {
		KIND_NUM   = 2'd0,  // normalize and round mag
		KIND_FIXED = 2'd1,  // result already known
		KIND_INF   = 2'd2
	} kind_t;

	typedef struct packed {
		kind_t        kind;
		logic         neg;
		logic [52:0]  mag;     // nonzero magnitude, bit 52 max
		logic signed [12:0] exp2; // value = mag * 2^exp2
		logic [31:0]  fixed_bits;
		logic         eob;
	} front_t;

	// Stage 2 to stage 3: normalized magnitude and biased exponent.
	typedef struct packed {
		kind_t        kind;
		logic         neg;
		logic [52:0]  norm;    // leading one at bit 52
		logic signed [12:0] ee;
		logic [31:0]  fixed_bits;
		logic         eob;
	} norm_t;

	typedef struct packed {
		logic [31:0] float_bits;
		logic        end_of_block;
	} result_t;

endpackage

### rtl/pstf_if.sv
interface pstf_in_if;
	logic        valid;
	logic        ready;
	logic [63:0] raw_sample;
	logic        end_of_block_in;
	modport source (output valid, raw_sample, end_of_block_in, input ready);
	modport sink (input valid, raw_sample, end_of_block_in, output ready);
endinterface

interface pstf_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] float_bits;
	logic        end_of_block_out;
	modport source (output valid, float_bits, end_of_block_out, input ready);
	modport sink (input valid, float_bits, end_of_block_out, output ready);
endinterface

### rtl/pstf_front.sv
module pstf_front import pstf_pkg::*; (
	input  logic [2:0]  sample_format,
	input  logic [63:0] raw_sample,
	input  logic        eob,
	output front_t      front
);
	logic [31:0] x32;
	logic [5:0]  n;
	logic        sgn;
	logic [32:0] mag_i;
	logic [10:0] e64;
	logic [51:0] f64;

	always_comb begin
		front = '0;
		front.eob = eob;
		front.kind = KIND_FIXED;
		x32 = '0;
		n = 6'd16;
		sgn = 1'b0;
		mag_i = '0;
		e64 = raw_sample[62:52];
		f64 = raw_sample[51:0];
		case (sample_format)
			FMT_INT8: begin
				x32 = {{24{raw_sample[7]}}, raw_sample[7:0]};
				n = 6'd8;
			end
			FMT_INT16: begin
				x32 = {{16{raw_sample[15]}}, raw_sample[15:0]};
				n = 6'd16;
			end
			FMT_INT24: begin
				x32 = {{8{raw_sample[23]}}, raw_sample[23:0]};
				n = 6'd24;
			end
			FMT_INT32: begin
				x32 = raw_sample[31:0];
				n = 6'd32;
			end
			default: ;
		endcase
		sgn = x32[31];
		mag_i = sgn ? (33'd0 - {1'b1, x32}) : {1'b0, x32};
		case (sample_format) inside
			FMT_INT8, FMT_INT16, FMT_INT24, FMT_INT32: begin
				if (mag_i != '0) begin
					front.kind = KIND_NUM;
					front.neg = sgn;
					front.mag = {20'd0, mag_i};
					front.exp2 = 13'sd1 - 13'(signed'({7'd0, n}));
				end
			end
			FMT_FLOAT32: front.fixed_bits = raw_sample[31:0];
			FMT_FLOAT64: begin
				front.neg = raw_sample[63];
				if (e64 == 11'h7ff) begin
					if (f64 == '0) front.kind = KIND_INF;
					else front.fixed_bits = {raw_sample[63], 31'(INF_BITS | QNAN_BIT)}
						| {9'd0, f64[51:29]};
				end else if (e64 == '0) begin
					front.fixed_bits = {raw_sample[63], 31'd0};
				end else begin
					front.kind = KIND_NUM;
					front.mag = {1'b1, f64};
					front.exp2 = 13'(signed'({2'b00, e64})) - 13'sd1075;
				end
			end
			default: ;
		endcase
	end
endmodule

### rtl/pstf_norm.sv
module pstf_norm import pstf_pkg::*; (
	input  front_t front,
	output norm_t  nrm
);
	logic [5:0] p;
	always_comb begin
		p = '0;
		for (int i = 0; i < 53; i++)
			if (front.mag[i]) p = 6'(i);
		nrm.kind = front.kind;
		nrm.neg = front.neg;
		nrm.fixed_bits = front.fixed_bits;
		nrm.eob = front.eob;
		nrm.norm = front.mag << (6'd52 - p);
		nrm.ee = front.exp2 + 13'(signed'({7'd0, p})) + 13'sd127;
	end
endmodule

### rtl/pstf_round.sv
module pstf_round import pstf_pkg::*; (
	input  norm_t       nrm,
	output logic [31:0] bits
);
	logic [12:0] ee_u;
	logic [6:0]  sh;     // right shift of norm to 24-bit-ish result
	logic [52:0] dn;
	logic        sticky_x, grd, stk, lsb, rup;
	logic [52:0] shifted;
	logic [31:0] mant;
	logic [31:0] val;
	logic [52:0] lost;
	always_comb begin
		ee_u = nrm.ee;
		// normal: keep 24 bits, shift 29; subnormal: extra 1-ee
		if (!nrm.ee[12] && nrm.ee != 13'sd0) sh = 7'd29;
		else if ((13'sd30 - nrm.ee) > 13'sd60) sh = 7'd60;
		else sh = 7'(13'sd30 - nrm.ee);
		dn = nrm.norm;
		shifted = dn >> sh;
		lost = dn & ~({53{1'b1}} << sh);
		// guard bit sits past the top of norm for very deep shifts
		grd = (sh == 7'd0) ? 1'b0 : ((dn & (53'd1 << (sh - 7'd1))) != '0);
		stk = ((lost & ~(53'd1 << (sh - 7'd1))) != '0);
		sticky_x = stk;
		lsb = shifted[0];
		rup = grd && (sticky_x || lsb);
		mant = 32'(shifted) + {31'd0, rup};
		if (!nrm.ee[12] && nrm.ee != 13'sd0)
			val = {ee_u[7:0] - 8'd1, 23'd0} + mant;
		else
			val = mant;
		if (!nrm.ee[12] && nrm.ee >= 13'sd255) val = INF_BITS;
		if (val >= INF_BITS) val = INF_BITS;
		case (nrm.kind)
			KIND_NUM:  bits = {nrm.neg, val[30:0]};
			KIND_INF:  bits = {nrm.neg, INF_BITS[30:0]};
			default:   bits = nrm.fixed_bits;
		endcase
	end
endmodule

### rtl/pcm_sample_to_float32.sv
// Channel  Dir  Payload                         Handshake
// in       in   raw_sample[63:0], end_of_block_in  valid/ready
// out      out  float_bits[31:0], end_of_block_out valid/ready
// cfg      in   sample_format_wdata[2:0]         sample_format_we
//
// One sample per cycle while out is not stalled; three pipeline registers
// (decode, normalize, round). Reset (arst_n, async) empties the
// pipe and sets the format to int16. A stall on out holds the output stage;
// an upstream stage moves only into a free slot, so bubbles are squeezed out
// and nothing is lost or repeated.
module pcm_sample_to_float32 import pstf_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              sample_format_we,
	input  logic [2:0]        sample_format_wdata,
	pstf_in_if.sink           in_ch,
	pstf_out_if.source        out_ch
);
	logic [2:0] fmt_q;
	front_t     front_c, front_s1;
	norm_t      norm_c, norm_s2;
	logic [31:0] bits_c;
	result_t    res_s3;
	logic       v_s1, v_s2, v_s3;
	logic       adv1, adv2, adv3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) fmt_q <= FORMAT_RESET;
		else if (sample_format_we) fmt_q <= sample_format_wdata;
	end

	// stage enables: a stage loads when it is empty or its content moves on
	assign adv3 = !v_s3 || out_ch.ready;
	assign adv2 = !v_s2 || adv3;
	assign adv1 = !v_s1 || adv2;
	assign in_ch.ready = adv1;

	pstf_front u_front (.sample_format(fmt_q), .raw_sample(in_ch.raw_sample),
		.eob(in_ch.end_of_block_in), .front(front_c));
	pstf_norm u_norm (.front(front_s1), .nrm(norm_c));
	pstf_round u_round (.nrm(norm_s2), .bits(bits_c));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (adv1) v_s1 <= in_ch.valid;
			if (adv2) v_s2 <= v_s1;
			if (adv3) v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1) front_s1 <= front_c;
		if (adv2) norm_s2 <= norm_c;
		if (adv3) begin
			res_s3.float_bits <= bits_c;
			res_s3.end_of_block <= norm_s2.eob;
		end
	end

	assign out_ch.valid = v_s3;
	assign out_ch.float_bits = res_s3.float_bits;
	assign out_ch.end_of_block_out = res_s3.end_of_block;

	// a stalled result stays put
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 && !out_ch.ready |=> v_s3 && $stable(res_s3))
		else $error("result changed under stall");
	// input is taken whenever the output side is free
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.ready |-> in_ch.ready)
		else $error("input blocked with free output");
	// an accepted request reaches stage 1
	a_s1: assert property (@(posedge clk) disable iff (!arst_n)
		in_ch.valid && in_ch.ready |=> v_s1)
		else $error("request lost at stage 1");
endmodule

### test/pcm_sample_to_float32_chk.sv
`timescale 1ns / 100ps

module pcm_sample_to_float32_chk import pstf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        sample_format_we,
	input  logic [2:0]  sample_format_wdata,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [63:0] in_raw,
	input  logic        in_eob,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [31:0] out_bits,
	input  logic        out_eob,
	output int          err_count,
	output int          pending
);

	logic [2:0] fmt_shadow;
	result_t    expected_q[$];

	function automatic logic [63:0] round_even(logic [63:0] m, int sh);
		logic [63:0] keep, rem, half;
		keep = m >> sh;
		rem  = m & ((64'd1 << sh) - 64'd1);
		half = 64'd1 << (sh - 1);
		if (rem > half || (rem == half && keep[0]))
			keep = keep + 64'd1;
		return keep;
	endfunction

	function automatic logic [31:0] pack_single(logic neg, logic [63:0] m, int exp2);
		logic [31:0] sgn, bits;
		logic [63:0] q;
		int p, ee, sh;
		sgn = neg ? 32'h8000_0000 : 32'h0;
		p = 0;
		while (p < 63 && (m >> (p + 1)) != 0)
			p++;
		ee = p + exp2 + 127;
		if (ee >= 255)
			return sgn | INF_BITS;
		sh = (ee >= 1) ? (p - 23) : (p - 23 + (1 - ee));
		if (sh <= 0)
			q = m << (-sh);
		else if (sh > 63)
			q = 0;
		else
			q = round_even(m, sh);
		bits = (ee >= 1) ? ((32'(ee - 1) << 23) + q[31:0]) : q[31:0];
		if (bits >= INF_BITS)
			bits = INF_BITS;
		return sgn | bits;
	endfunction

	function automatic logic [31:0] int_to_single(logic [63:0] raw, int n);
		logic [63:0] x, m;
		logic neg;
		x = raw & ((64'd1 << n) - 64'd1);
		neg = x[n - 1];
		m = neg ? ((64'd1 << n) - x) : x;
		if (m == 0)
			return 32'h0;
		return pack_single(neg, m, -(n - 1));
	endfunction

	function automatic logic [31:0] double_to_single(logic [63:0] raw);
		logic [31:0] sgn;
		logic [10:0] e;
		logic [51:0] f;
		sgn = raw[63] ? 32'h8000_0000 : 32'h0;
		e = raw[62:52];
		f = raw[51:0];
		if (e == 11'h7ff)
			return (f == 0) ? (sgn | INF_BITS) : (sgn | INF_BITS | QNAN_BIT | 32'(f >> 29));
		if (e == 0)
			return sgn;
		return pack_single(raw[63], {11'd0, 1'b1, f}, int'(e) - 1023 - 52);
	endfunction

	function automatic logic [31:0] convert_sample(logic [2:0] fmt, logic [63:0] raw);
		case (fmt)
			FMT_INT8:    return int_to_single(raw, 8);
			FMT_INT16:   return int_to_single(raw, 16);
			FMT_INT24:   return int_to_single(raw, 24);
			FMT_INT32:   return int_to_single(raw, 32);
			FMT_FLOAT32: return raw[31:0];
			FMT_FLOAT64: return double_to_single(raw);
			default:     return 32'h0;
		endcase
	endfunction

	always @(posedge clk or negedge arst_n) begin
		result_t exp_r;
		if (!arst_n) begin
			fmt_shadow = FORMAT_RESET;
			expected_q.delete();
			err_count = 0;
			pending = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_q.size() == 0) begin
					$error("unexpected result float_bits=%h", out_bits);
					err_count++;
				end else begin
					exp_r = expected_q.pop_front();
					if (out_bits !== exp_r.float_bits) begin
						$error("float_bits expected %h actual %h", exp_r.float_bits, out_bits);
						err_count++;
					end
					if (out_eob !== exp_r.end_of_block) begin
						$error("end_of_block_out expected %b actual %b",
							exp_r.end_of_block, out_eob);
						err_count++;
					end
				end
			end
			if (in_valid && in_ready)
				expected_q.push_back('{convert_sample(fmt_shadow, in_raw), in_eob});
			if (sample_format_we)
				fmt_shadow = sample_format_wdata;
			pending = expected_q.size();
		end
	end

endmodule

### test/pcm_sample_to_float32_tb.sv
`timescale 1ns / 100ps

module pcm_sample_to_float32_tb import pstf_pkg::*;;

	logic       clk;
	logic       arst_n;
	logic       sample_format_we;
	logic [2:0] sample_format_wdata;
	int         err_count;
	int         pending;
	int         send_idle_pct;   // sender gap odds, percent
	int         recv_stall_pct;  // receiver stall odds, percent

	pstf_in_if  in_ch ();
	pstf_out_if out_ch ();

	pcm_sample_to_float32 dut (
		.clk                 (clk),
		.arst_n              (arst_n),
		.sample_format_we    (sample_format_we),
		.sample_format_wdata (sample_format_wdata),
		.in_ch               (in_ch),
		.out_ch              (out_ch)
	);

	pcm_sample_to_float32_chk chk (
		.clk                 (clk),
		.arst_n              (arst_n),
		.sample_format_we    (sample_format_we),
		.sample_format_wdata (sample_format_wdata),
		.in_valid            (in_ch.valid),
		.in_ready            (in_ch.ready),
		.in_raw              (in_ch.raw_sample),
		.in_eob              (in_ch.end_of_block_in),
		.out_valid           (out_ch.valid),
		.out_ready           (out_ch.ready),
		.out_bits            (out_ch.float_bits),
		.out_eob             (out_ch.end_of_block_out),
		.err_count           (err_count),
		.pending             (pending)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Hard stop; the slowest legal run is far shorter than this.
	initial begin
		#20ms;
		$display("DONE: errors detected");
		$finish;
	end

	// Receiver: random backpressure, odds set by the phase.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
		end else begin
			out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// One request; valid stays up across back-to-back requests.
	task automatic send_sample(logic [63:0] raw, logic eob);
		while ($urandom_range(99) < send_idle_pct) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid           <= 1'b1;
		in_ch.raw_sample      <= raw;
		in_ch.end_of_block_in <= eob;
		do @(posedge clk); while (!in_ch.ready);
	endtask

	// Drain the pipe, let the three stages settle, then write the format.
	task automatic set_format(logic [2:0] fmt);
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		sample_format_we    <= 1'b1;
		sample_format_wdata <= fmt;
		@(posedge clk);
		sample_format_we <= 1'b0;
	endtask

	// Random raw word shaped for the format in use.
	function automatic logic [63:0] pick_raw(logic [2:0] fmt);
		logic [63:0] r;
		logic [10:0] e;
		r = {$urandom, $urandom};
		if (fmt == FMT_FLOAT64) begin
			case ($urandom_range(5))
				0: e = 11'h7ff;
				1: e = 11'h0;
				2: e = 11'(874 + $urandom_range(30));   // single subnormal range and just above
				3: e = 11'(1150 + $urandom_range(30));  // near overflow
				default: e = 11'(1023 - 20 + $urandom_range(40));
			endcase
			r[62:52] = e;
			if ($urandom_range(7) == 0)
				r[28:0] = {1'b1, 28'h0};  // exact tie
		end else if ($urandom_range(9) == 0) begin
			// All ones, all zeros or just the sign in the low bits.
			case ($urandom_range(2))
				0: r = '0;
				1: r = '1;
				default: r = 64'h8000_0000 >> (8 * (3 - (fmt < 3 ? fmt : 3)));
			endcase
		end
		return r;
	endfunction

	initial begin
		logic [2:0] fmt;
		arst_n              = 1'b0;
		sample_format_we    = 1'b0;
		sample_format_wdata = FORMAT_RESET;
		in_ch.valid           = 1'b0;
		in_ch.raw_sample      = '0;
		in_ch.end_of_block_in = 1'b0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: reset format (int16), then edge values of each format.
		send_sample(64'h0, 1'b0);
		send_sample(64'hffff_ffff_ffff_7fff, 1'b1);
		send_sample(64'h8000, 1'b0);
		set_format(FMT_INT8);
		send_sample(64'h80, 1'b0);
		send_sample(64'h7f, 1'b1);
		set_format(FMT_INT24);
		send_sample(64'h80_0000, 1'b0);
		send_sample(64'hff_ffff, 1'b0);
		set_format(FMT_INT32);
		send_sample(64'h7fff_ffff, 1'b0);    // rounds up to 1.0
		send_sample(64'h8000_0000, 1'b0);
		send_sample(64'h0100_0001, 1'b0);    // tie, stays even
		send_sample(64'h0100_0003, 1'b0);    // tie, rounds up
		set_format(FMT_FLOAT32);
		send_sample(64'hdead_beef_7fc0_0001, 1'b1);
		set_format(FMT_FLOAT64);
		send_sample(64'h7ff0_0000_0000_0000, 1'b0);  // +inf
		send_sample(64'hfff8_0000_2000_0000, 1'b0);  // NaN
		send_sample(64'h7ff0_0000_0000_0001, 1'b0);  // signaling NaN, quieted
		send_sample(64'h8000_0000_0000_0001, 1'b0);  // double subnormal
		send_sample(64'h47f0_0000_0000_0000, 1'b0);  // overflow
		send_sample(64'h36a0_0000_0000_0000, 1'b0);  // smallest single subnormal
		send_sample(64'h3690_0000_0000_0000, 1'b0);  // half of it, ties to zero
		send_sample(64'h3ff0_0000_0000_0000, 1'b1);
		set_format(3'd6);
		send_sample(64'hffff_ffff_ffff_ffff, 1'b1);
		set_format(3'd7);
		send_sample(64'h1234_5678_9abc_def0, 1'b0);

		// Random phases: each picks a format and an idling mix.
		for (int ph = 0; ph < 16; ph++) begin
			fmt = (ph < 8) ? 3'(ph) : 3'($urandom_range(5));
			set_format(fmt);
			case (ph % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 69; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 69; end
				default: begin send_idle_pct = 22; recv_stall_pct = 22; end
			endcase
			for (int k = 0; k < 24; k++) begin
				send_sample(pick_raw(fmt), $urandom_range(1));
				// Once, in phase 5, hold off until the pipe is empty.
				if (k == 12 && ph == 5) begin
					in_ch.valid <= 1'b0;
					@(posedge clk);
					while (pending != 0)
						@(posedge clk);
				end
			end
		end

		in_ch.valid <= 1'b0;
		recv_stall_pct = 0;
		while (pending != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (err_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
